### rtl/lfpd_pkg.sv
package lfpd_pkg;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_PROP_GAIN     = 3'd0,
        REG_INTEG_GAIN    = 3'd1,
        REG_DERIV_GAIN    = 3'd2,
        REG_BASE_SPEED    = 3'd3,
        REG_ON_LINE_LEVEL = 3'd4,
        REG_DARK_LEVEL    = 3'd5,
        REG_CRUISE_BAND   = 3'd6
    } reg_idx_t;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;
    localparam int GAIN_W     = 12;
    localparam int LEVEL_W    = 8;
    localparam int DRIVE_W    = 8;

    // Motor direction nibble
    typedef enum logic [3:0] {
        DIR_STOP       = 4'h0,
        DIR_SPIN_LEFT  = 4'h5,
        DIR_FORWARD    = 4'h6,
        DIR_SPIN_RIGHT = 4'hA
    } dir_t;

    localparam int DRIVE_MAX   = 250;
    localparam int DARK_DRIVE  = 200;
    localparam int INNER_EDGE  = 60;
    localparam int OUTER_EDGE  = 120;

    localparam logic [GAIN_W-1:0]  PROP_GAIN_RST     = 12'd307;
    localparam logic [GAIN_W-1:0]  INTEG_GAIN_RST    = 12'd0;
    localparam logic [GAIN_W-1:0]  DERIV_GAIN_RST    = 12'd128;
    localparam logic [LEVEL_W-1:0] BASE_SPEED_RST    = 8'd90;
    localparam logic [LEVEL_W-1:0] ON_LINE_LEVEL_RST = 8'd40;
    localparam logic [LEVEL_W-1:0] DARK_LEVEL_RST    = 8'd20;
    localparam logic [LEVEL_W-1:0] CRUISE_BAND_RST   = 8'd20;

    typedef struct packed {
        logic [GAIN_W-1:0]  prop_gain;
        logic [GAIN_W-1:0]  integ_gain;
        logic [GAIN_W-1:0]  deriv_gain;
        logic [LEVEL_W-1:0] base_speed;
        logic [LEVEL_W-1:0] on_line_level;
        logic [LEVEL_W-1:0] dark_level;
        logic [LEVEL_W-1:0] cruise_band;
    } cfg_t;

endpackage

### rtl/lfpd_cfg_regs.sv
module lfpd_cfg_regs import lfpd_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.prop_gain     <= PROP_GAIN_RST;
            cfg_reg.integ_gain    <= INTEG_GAIN_RST;
            cfg_reg.deriv_gain    <= DERIV_GAIN_RST;
            cfg_reg.base_speed    <= BASE_SPEED_RST;
            cfg_reg.on_line_level <= ON_LINE_LEVEL_RST;
            cfg_reg.dark_level    <= DARK_LEVEL_RST;
            cfg_reg.cruise_band   <= CRUISE_BAND_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_PROP_GAIN:     cfg_reg.prop_gain     <= cfg_data[GAIN_W-1:0];
                REG_INTEG_GAIN:    cfg_reg.integ_gain    <= cfg_data[GAIN_W-1:0];
                REG_DERIV_GAIN:    cfg_reg.deriv_gain    <= cfg_data[GAIN_W-1:0];
                REG_BASE_SPEED:    cfg_reg.base_speed    <= cfg_data[LEVEL_W-1:0];
                REG_ON_LINE_LEVEL: cfg_reg.on_line_level <= cfg_data[LEVEL_W-1:0];
                REG_DARK_LEVEL:    cfg_reg.dark_level    <= cfg_data[LEVEL_W-1:0];
                REG_CRUISE_BAND:   cfg_reg.cruise_band   <= cfg_data[LEVEL_W-1:0];
                default: ;  // unknown index: drop the write
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

### rtl/lfpd_pid_path.sv
module lfpd_pid_path import lfpd_pkg::*; #(
    parameter int SAMPLE_BITS    = 8,
    parameter int GAIN_FRAC_BITS = 8,
    parameter int SUM_BITS       = 24,
    parameter int CTL_W          = 32
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    step,
    input  logic [SAMPLE_BITS-1:0]  left_level,
    input  logic [SAMPLE_BITS-1:0]  right_level,
    input  cfg_t                    cfg,
    output logic signed [CTL_W-1:0] ctl
);

    localparam int ERR_W = SAMPLE_BITS + 1;
    localparam int DER_W = SAMPLE_BITS + 2;
    localparam int ACC_W = SUM_BITS + 15;

    localparam logic signed [SUM_BITS-1:0] SUM_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};
    localparam logic signed [SUM_BITS-1:0] SUM_MIN = {1'b1, {(SUM_BITS-1){1'b0}}};

    logic signed [ERR_W-1:0]    prev_err_reg;
    logic signed [SUM_BITS-1:0] sum_reg;

    logic signed [ERR_W-1:0]    err;
    logic signed [DER_W-1:0]    deriv;
    logic signed [SUM_BITS:0]   sum_wide;
    logic signed [SUM_BITS-1:0] sum_next;
    logic signed [ACC_W-1:0]    prop_term;
    logic signed [ACC_W-1:0]    integ_term;
    logic signed [ACC_W-1:0]    deriv_term;
    logic signed [ACC_W-1:0]    acc;
    logic        [ACC_W-1:0]    acc_mag;
    logic        [ACC_W-1:0]    mag_shift;

    always_comb begin
        err      = $signed({1'b0, right_level}) - $signed({1'b0, left_level});
        deriv    = DER_W'(err) - DER_W'(prev_err_reg);
        sum_wide = (SUM_BITS+1)'(sum_reg) + (SUM_BITS+1)'(err);
        // saturate the running sum when the two top bits disagree
        if (sum_wide[SUM_BITS] != sum_wide[SUM_BITS-1]) begin
            sum_next = sum_wide[SUM_BITS] ? SUM_MIN : SUM_MAX;
        end else begin
            sum_next = sum_wide[SUM_BITS-1:0];
        end

        prop_term  = ACC_W'($signed({1'b0, cfg.prop_gain}))  * ACC_W'(err);
        integ_term = ACC_W'($signed({1'b0, cfg.integ_gain})) * ACC_W'(sum_next);
        deriv_term = ACC_W'($signed({1'b0, cfg.deriv_gain})) * ACC_W'(deriv);
        acc        = prop_term + integ_term + deriv_term;

        // truncate toward zero: shift the magnitude, then restore the sign
        acc_mag   = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
        mag_shift = acc_mag >> GAIN_FRAC_BITS;
        ctl       = acc[ACC_W-1] ? -$signed(CTL_W'(mag_shift)) : $signed(CTL_W'(mag_shift));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_err_reg <= '0;
            sum_reg      <= '0;
        end else if (step) begin
            prev_err_reg <= err;
            sum_reg      <= sum_next;
        end
    end

endmodule

### rtl/lfpd_drive_sched.sv
module lfpd_drive_sched import lfpd_pkg::*; #(
    parameter int SAMPLE_BITS = 8,
    parameter int CTL_W       = 32
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    step,
    input  logic signed [CTL_W-1:0] ctl,
    input  logic [SAMPLE_BITS-1:0]  left_level,
    input  logic [SAMPLE_BITS-1:0]  centre_level,
    input  logic [SAMPLE_BITS-1:0]  right_level,
    input  cfg_t                    cfg,
    output logic [DRIVE_W-1:0]      left_drive,
    output logic [DRIVE_W-1:0]      right_drive,
    output dir_t                    wheel_direction,
    output logic                    pause_request
);

    localparam int SUMW = CTL_W + 1;

    localparam logic signed [CTL_W-1:0] INNER_P = CTL_W'(INNER_EDGE);
    localparam logic signed [CTL_W-1:0] INNER_N = -CTL_W'(INNER_EDGE);
    localparam logic signed [CTL_W-1:0] OUTER_P = CTL_W'(OUTER_EDGE);
    localparam logic signed [CTL_W-1:0] OUTER_N = -CTL_W'(OUTER_EDGE);
    localparam logic signed [SUMW-1:0]  DMAX_S  = SUMW'(DRIVE_MAX);

    logic [DRIVE_W-1:0] held_left_reg,  held_left_next;
    logic [DRIVE_W-1:0] held_right_reg, held_right_next;
    dir_t               dir_reg,        dir_next;

    logic signed [SUMW-1:0]  base_s;
    logic signed [SUMW-1:0]  ctl_s;
    logic [DRIVE_W-1:0]      drive_plus;
    logic [DRIVE_W-1:0]      drive_minus;
    logic signed [CTL_W-1:0] cruise_p;
    logic signed [CTL_W-1:0] cruise_n;
    logic                    on_line;
    logic                    all_dark;
    logic                    cruising;

    function automatic logic [DRIVE_W-1:0] clamp_drive(input logic signed [SUMW-1:0] v);
        logic [DRIVE_W-1:0] r;
        if (v < 0) begin
            r = '0;
        end else if (v > DMAX_S) begin
            r = DRIVE_W'(DRIVE_MAX);
        end else begin
            r = v[DRIVE_W-1:0];
        end
        return r;
    endfunction

    always_comb begin
        base_s      = $signed(SUMW'(cfg.base_speed));
        ctl_s       = SUMW'(ctl);
        drive_plus  = clamp_drive(base_s + ctl_s);
        drive_minus = clamp_drive(base_s - ctl_s);
        cruise_p    = $signed(CTL_W'(cfg.cruise_band));
        cruise_n    = -cruise_p;
        on_line     = centre_level > SAMPLE_BITS'(cfg.on_line_level);
        all_dark    = (left_level   < SAMPLE_BITS'(cfg.dark_level)) &&
                      (centre_level < SAMPLE_BITS'(cfg.dark_level)) &&
                      (right_level  < SAMPLE_BITS'(cfg.dark_level));
        cruising    = on_line && (ctl < cruise_p) && (ctl > cruise_n);
    end

    // Band schedule; exact band edges leave the held drives alone
    always_comb begin
        held_left_next  = held_left_reg;
        held_right_next = held_right_reg;
        dir_next        = dir_reg;
        if (on_line) begin
            dir_next = DIR_FORWARD;
        end
        if (ctl > INNER_N && ctl < INNER_P) begin
            held_left_next  = drive_plus;
            held_right_next = drive_minus;
        end else if (ctl > INNER_P && ctl < OUTER_P) begin
            held_left_next  = drive_plus;
            held_right_next = '0;
        end else if (ctl > OUTER_P) begin
            dir_next        = DIR_SPIN_RIGHT;
            held_left_next  = drive_plus;
            held_right_next = drive_plus;
        end else if (ctl < INNER_N && ctl > OUTER_N) begin
            held_left_next  = '0;
            held_right_next = drive_minus;
        end else if (ctl < OUTER_N) begin
            dir_next        = DIR_SPIN_LEFT;
            held_left_next  = drive_minus;
            held_right_next = drive_minus;
        end
        if (all_dark || cruising) begin
            dir_next = DIR_FORWARD;
        end
    end

    // Overrides pick what is driven
    always_comb begin
        wheel_direction = dir_next;
        pause_request   = 1'b0;
        if (all_dark) begin
            left_drive    = DRIVE_W'(DARK_DRIVE);
            right_drive   = DRIVE_W'(DARK_DRIVE);
            pause_request = 1'b1;
        end else if (cruising) begin
            left_drive  = DRIVE_W'(DRIVE_MAX);
            right_drive = DRIVE_W'(DRIVE_MAX);
        end else begin
            left_drive  = held_left_next;
            right_drive = held_right_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_left_reg  <= '0;
            held_right_reg <= '0;
            dir_reg        <= DIR_STOP;
        end else if (step) begin
            held_left_reg  <= held_left_next;
            held_right_reg <= held_right_next;
            dir_reg        <= dir_next;
        end
    end

endmodule

### rtl/line_follow_pd_drive_step_core.sv
// Line-follower steering core. Each input beat carries left, centre and right
// sensor levels; each output beat carries the left and right wheel drive
// (0..250), the motor direction nibble and a pause request raised when all
// three sensors read dark. One result beat comes out for every input beat.
// A beat is held in the input register, the PID terms, band schedule
// and overrides are worked out in a single pass behind it, and the result is
// loaded into the output register. A new beat is accepted every cycle while
// the output is free or draining, and the error history, running sum and
// held drives are updated for each beat taken on. While a result waits on the
// output, one more beat is taken into the empty input register and the input
// then stalls until the waiting result leaves. Registers are to be written by
// the user through the cfg port only while idle; the core does not enforce it.
module line_follow_pd_drive_step_core import lfpd_pkg::*; #(
    parameter int SAMPLE_BITS    = 8,
    parameter int GAIN_FRAC_BITS = 8,
    parameter int SUM_BITS       = 24
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    // left_level, centre_level, right_level (SAMPLE_BITS each), zero pad
    input  logic [((3*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,

    output logic                  m_tvalid,
    input  logic                  m_tready,
    // left_drive[7:0], right_drive[15:8], wheel_direction[19:16],
    // pause_request[20], zero pad
    output logic [23:0]           m_tdata,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int IN_W  = 3 * SAMPLE_BITS;
    localparam int ACC_W = SUM_BITS + 15;
    localparam int CTL_W = ACC_W - GAIN_FRAC_BITS + 1;
    localparam int OUT_W = 2 * DRIVE_W + 4 + 1;

    cfg_t cfg;

    logic             in_valid_reg;
    logic [IN_W-1:0]  in_data_reg;
    logic             out_valid_reg;
    logic [OUT_W-1:0] out_data_reg;
    logic             advance;

    logic [SAMPLE_BITS-1:0]  left_level;
    logic [SAMPLE_BITS-1:0]  centre_level;
    logic [SAMPLE_BITS-1:0]  right_level;
    logic signed [CTL_W-1:0] ctl;
    logic [DRIVE_W-1:0]      left_drive;
    logic [DRIVE_W-1:0]      right_drive;
    dir_t                    wheel_direction;
    logic                    pause_request;

    assign cfg_ready = 1'b1;

    lfpd_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // move the held beat on whenever the output register is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign left_level   = in_data_reg[SAMPLE_BITS-1:0];
    assign centre_level = in_data_reg[2*SAMPLE_BITS-1:SAMPLE_BITS];
    assign right_level  = in_data_reg[3*SAMPLE_BITS-1:2*SAMPLE_BITS];

    lfpd_pid_path #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
        .SUM_BITS       (SUM_BITS),
        .CTL_W          (CTL_W)
    ) u_pid (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (advance),
        .left_level  (left_level),
        .right_level (right_level),
        .cfg         (cfg),
        .ctl         (ctl)
    );

    lfpd_drive_sched #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .CTL_W       (CTL_W)
    ) u_sched (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .step            (advance),
        .ctl             (ctl),
        .left_level      (left_level),
        .centre_level    (centre_level),
        .right_level     (right_level),
        .cfg             (cfg),
        .left_drive      (left_drive),
        .right_drive     (right_drive),
        .wheel_direction (wheel_direction),
        .pause_request   (pause_request)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg <= s_tdata[IN_W-1:0];
        end
        if (advance) begin
            out_data_reg <= {pause_request, wheel_direction, right_drive, left_drive};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(24-OUT_W){1'b0}}, out_data_reg};

    a_advance_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_valid_reg)
        else $error("result register not loaded after advance");

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_data_reg))
        else $error("stalled input beat lost or changed");

    a_pause_drive: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_data_reg[OUT_W-1] |->
            out_data_reg[DRIVE_W-1:0] == DRIVE_W'(DARK_DRIVE) &&
            out_data_reg[2*DRIVE_W-1:DRIVE_W] == DRIVE_W'(DARK_DRIVE) &&
            out_data_reg[2*DRIVE_W+3:2*DRIVE_W] == DIR_FORWARD)
        else $error("pause beat without dark drive");

    a_drive_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |->
            out_data_reg[DRIVE_W-1:0] <= DRIVE_W'(DRIVE_MAX) &&
            out_data_reg[2*DRIVE_W-1:DRIVE_W] <= DRIVE_W'(DRIVE_MAX))
        else $error("drive beyond limit");

endmodule

### verif/tb.sv
module tb;
    import lfpd_pkg::*;

    localparam int     GAIN_FRAC_BITS = 8;
    localparam int     SUM_BITS       = 24;
    localparam longint SUM_MAX        = (longint'(1) <<< (SUM_BITS - 1)) - 1;
    localparam longint SUM_MIN        = -SUM_MAX - 1;
    localparam int     CYCLE_LIMIT    = 900_000;
    // register index past the end of the map; writes to it are dropped
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef struct {
        logic [DRIVE_W-1:0] left_drive;
        logic [DRIVE_W-1:0] right_drive;
        dir_t               wheel_direction;
        logic               pause_request;
    } drive_result_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // left_level[7:0], centre_level[15:8], right_level[23:16]
    logic [23:0]           s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // left_drive[7:0], right_drive[15:8], wheel_direction[19:16], pause_request[20]
    logic [23:0]           m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // predictor state, tracking the block beat by beat
    cfg_t          regs;
    int            prev_error;
    longint        error_sum;
    logic [7:0]    held_left;
    logic [7:0]    held_right;
    dir_t          steer_dir;
    drive_result_t pending_drives[$];
    drive_result_t want;

    int          mismatches = 0;
    int          cycle_count = 0;
    int          burst_left = 0;
    bit          tx_gaps = 1'b0;
    bit          rx_stalls = 1'b0;
    int          rx_hold = 0;
    logic [15:0] rx_pattern = '0;
    logic [3:0]  rx_tick = '0;

    line_follow_pd_drive_step_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic logic [7:0] clamp_drive(input longint v);
        if (v < 0) return 8'd0;
        if (v > DRIVE_MAX) return 8'(DRIVE_MAX);
        return 8'(v);
    endfunction

    function automatic drive_result_t predict_drive(input logic [7:0] l, c, r);
        int            err;
        int            slope;
        longint        acc;
        longint        ctl;
        longint        base;
        longint        band;
        drive_result_t res;
        err = int'(l) * -1 + int'(r);
        slope = err - prev_error;
        error_sum += err;
        if (error_sum > SUM_MAX) error_sum = SUM_MAX;
        if (error_sum < SUM_MIN) error_sum = SUM_MIN;
        acc = longint'(regs.prop_gain) * err + longint'(regs.integ_gain) * error_sum
            + longint'(regs.deriv_gain) * slope;
        // truncate toward zero
        ctl = (acc < 0) ? -((-acc) >>> GAIN_FRAC_BITS) : (acc >>> GAIN_FRAC_BITS);
        base = longint'(regs.base_speed);
        band = longint'(regs.cruise_band);

        if (c > regs.on_line_level) steer_dir = DIR_FORWARD;
        if (ctl > -INNER_EDGE && ctl < INNER_EDGE) begin
            held_left = clamp_drive(base + ctl);
            held_right = clamp_drive(base - ctl);
        end else if (ctl > INNER_EDGE && ctl < OUTER_EDGE) begin
            held_right = 8'd0;
            held_left = clamp_drive(base + ctl);
        end else if (ctl > OUTER_EDGE) begin
            steer_dir = DIR_SPIN_RIGHT;
            held_left = clamp_drive(base + ctl);
            held_right = held_left;
        end else if (ctl < -INNER_EDGE && ctl > -OUTER_EDGE) begin
            held_left = 8'd0;
            held_right = clamp_drive(base - ctl);
        end else if (ctl < -OUTER_EDGE) begin
            steer_dir = DIR_SPIN_LEFT;
            held_left = clamp_drive(base - ctl);
            held_right = held_left;
        end
        // exactly on a band edge: hold drives
        prev_error = err;

        res.pause_request = 1'b0;
        if (l < regs.dark_level && r < regs.dark_level && c < regs.dark_level) begin
            steer_dir = DIR_FORWARD;
            res.left_drive = 8'(DARK_DRIVE);
            res.right_drive = 8'(DARK_DRIVE);
            res.pause_request = 1'b1;
        end else if (c > regs.on_line_level && ctl < band && ctl > -band) begin
            steer_dir = DIR_FORWARD;
            res.left_drive = 8'(DRIVE_MAX);
            res.right_drive = 8'(DRIVE_MAX);
        end else begin
            res.left_drive = held_left;
            res.right_drive = held_right;
        end
        res.wheel_direction = steer_dir;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int exp_val);
        if (mismatches < 40)
            $display("[%0t] %s: got %0d, expected %0d", $time, what, got, exp_val);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_drives.size() == 0) begin
                report_mismatch("result beat with nothing pending", int'(m_tdata), 0);
            end else begin
                want = pending_drives.pop_front();
                if (m_tdata[7:0] !== want.left_drive)
                    report_mismatch("left_drive", int'(m_tdata[7:0]),
                                    int'(want.left_drive));
                if (m_tdata[15:8] !== want.right_drive)
                    report_mismatch("right_drive", int'(m_tdata[15:8]),
                                    int'(want.right_drive));
                if (m_tdata[19:16] !== want.wheel_direction)
                    report_mismatch("wheel_direction", int'(m_tdata[19:16]),
                                    int'(want.wheel_direction));
                if (m_tdata[20] !== want.pause_request)
                    report_mismatch("pause_request", int'(m_tdata[20]),
                                    int'(want.pause_request));
                if (m_tdata[23:21] !== 3'b000)
                    report_mismatch("tdata pad", int'(m_tdata[23:21]), 0);
            end
        end
    end

    // receiver: long hold-off when asked, otherwise always ready or a rolling stall pattern
    always @(negedge aclk) begin
        if (rx_hold > 0) begin
            m_tready = 1'b0;
            rx_hold--;
        end else if (!rx_stalls) begin
            m_tready = 1'b1;
        end else begin
            if (rx_tick == 4'd0) rx_pattern = 16'($urandom);
            m_tready = rx_pattern[rx_tick] | rx_pattern[rx_tick ^ 4'd5];
            rx_tick++;
        end
    end

    // called at a falling edge, returns at a falling edge with tvalid low
    task automatic send_levels(input logic [7:0] l, c, r);
        if (tx_gaps && burst_left == 0) begin
            repeat ($urandom_range(1, 7)) @(negedge aclk);
            burst_left = $urandom_range(1, 24);
        end
        s_tdata = {r, c, l};
        s_tvalid = 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_drives.push_back(predict_drive(l, c, r));
        @(negedge aclk);
        s_tvalid = 1'b0;
        if (burst_left > 0) burst_left--;
    endtask

    // write only once every result is out and the pipeline has emptied
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        while (pending_drives.size() != 0) @(negedge aclk);
        repeat (3) @(negedge aclk);
        cfg_index = idx;
        cfg_data = val;
        cfg_valid = 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_PROP_GAIN:     regs.prop_gain = val;
            REG_INTEG_GAIN:    regs.integ_gain = val;
            REG_DERIV_GAIN:    regs.deriv_gain = val;
            REG_BASE_SPEED:    regs.base_speed = val[7:0];
            REG_ON_LINE_LEVEL: regs.on_line_level = val[7:0];
            REG_DARK_LEVEL:    regs.dark_level = val[7:0];
            REG_CRUISE_BAND:   regs.cruise_band = val[7:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic write_all(input int pg, ig, dg, bs, ol, dl, cb);
        write_reg(REG_PROP_GAIN, CFG_DATA_W'(pg));
        write_reg(REG_INTEG_GAIN, CFG_DATA_W'(ig));
        write_reg(REG_DERIV_GAIN, CFG_DATA_W'(dg));
        write_reg(REG_BASE_SPEED, CFG_DATA_W'(bs));
        write_reg(REG_ON_LINE_LEVEL, CFG_DATA_W'(ol));
        write_reg(REG_DARK_LEVEL, CFG_DATA_W'(dl));
        write_reg(REG_CRUISE_BAND, CFG_DATA_W'(cb));
    endtask

    // reset registers: hard stop, dark, cruise, spins and the dark threshold
    task automatic test_power_up();
        logic [7:0] lv[9] = '{30, 0, 100, 0, 255, 255, 19, 20, 19};
        logic [7:0] cv[9] = '{30, 0, 200, 255, 255, 255, 19, 20, 19};
        logic [7:0] rv[9] = '{30, 0, 100, 255, 0, 255, 19, 20, 20};
        tx_gaps = 1'b0;
        rx_stalls = 1'b0;
        foreach (lv[i]) send_levels(lv[i], cv[i], rv[i]);
    endtask

    // unit proportional gain makes the control value equal the error
    task automatic test_band_edges();
        int band_points[14] = '{0, 60, 59, 60, 61, 119, 120, 121,
                                -59, -60, -61, -119, -120, -121};
        int low_base[3] = '{30, -30, 0};
        write_all(256, 0, 0, 200, 255, 0, 0);
        write_reg(REG_UNUSED, 12'hFFF);
        foreach (band_points[i])
            send_levels(band_points[i] < 0 ? 8'(-band_points[i]) : 8'd0, 8'd128,
                        band_points[i] > 0 ? 8'(band_points[i]) : 8'd0);
        // upper bits beyond the register width are dropped: base becomes zero
        write_reg(REG_BASE_SPEED, 12'h300);
        foreach (low_base[i])
            send_levels(low_base[i] < 0 ? 8'(-low_base[i]) : 8'd0, 8'd128,
                        low_base[i] > 0 ? 8'(low_base[i]) : 8'd0);
    endtask

    task automatic test_random_tracks();
        int         kind;
        int         t;
        logic [7:0] l, c, r, sw;
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: write_all(0, 0, 0, 0, 0, 0, 0);
                1: write_all(4095, 4095, 4095, 255, 255, 255, 255);
                default: write_all($urandom_range(0, 800), $urandom_range(0, 8),
                                   $urandom_range(0, 600),
                                   $urandom_range(0, 255) | ($urandom_range(0, 15) << 8),
                                   $urandom_range(0, 255), $urandom_range(0, 80),
                                   $urandom_range(0, 255) | ($urandom_range(0, 15) << 8));
            endcase
            tx_gaps = (p % 3 != 2);
            rx_stalls = (p % 2 == 0) || (p == 5);
            for (int n = 0; n < 60; n++) begin
                kind = $urandom_range(0, 9);
                l = 8'($urandom_range(0, 255));
                c = 8'($urandom_range(0, 255));
                r = 8'($urandom_range(0, 255));
                if (kind < 4) begin
                    // riding the line: centre high, sides close together
                    c = 8'($urandom_range(255, regs.on_line_level));
                    t = int'(l) + int'($urandom_range(0, 16)) - 8;
                    r = (t < 0) ? 8'd0 : (t > 255) ? 8'd255 : 8'(t);
                end else if (kind == 4 && regs.dark_level > 0) begin
                    l = 8'($urandom_range(0, regs.dark_level - 1));
                    c = 8'($urandom_range(0, regs.dark_level - 1));
                    r = 8'($urandom_range(0, regs.dark_level - 1));
                end else if (kind < 7) begin
                    // hard turn
                    l = 8'($urandom_range(0, 40));
                    r = 8'($urandom_range(180, 255));
                    if ($urandom_range(0, 1)) begin
                        sw = l;
                        l = r;
                        r = sw;
                    end
                end
                send_levels(l, c, r);
            end
        end
    endtask

    // hold the receiver off long enough for the block to back up its input
    task automatic test_backpressure();
        write_all(307, 2, 128, 90, 40, 20, 20);
        tx_gaps = 1'b0;
        rx_stalls = 1'b1;
        rx_hold = 300;
        for (int n = 0; n < 40; n++)
            send_levels(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                        8'($urandom_range(0, 255)));
    endtask

    // the control value follows the running sum: wind it up into the outer
    // band, then unwind it back down through every band to the far side
    task automatic test_integral_windup();
        write_all(0, 64, 0, 90, 255, 0, 0);
        tx_gaps = 1'b0;
        rx_stalls = 1'b0;
        repeat (30) send_levels(8'd0, 8'($urandom_range(0, 255)), 8'd255);
        repeat (40) send_levels(8'd255, 8'($urandom_range(0, 255)), 8'd0);
    endtask

    initial begin
        regs.prop_gain = PROP_GAIN_RST;
        regs.integ_gain = INTEG_GAIN_RST;
        regs.deriv_gain = DERIV_GAIN_RST;
        regs.base_speed = BASE_SPEED_RST;
        regs.on_line_level = ON_LINE_LEVEL_RST;
        regs.dark_level = DARK_LEVEL_RST;
        regs.cruise_band = CRUISE_BAND_RST;
        prev_error = 0;
        error_sum = 0;
        held_left = '0;
        held_right = '0;
        steer_dir = DIR_STOP;

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_power_up();
        test_band_edges();
        test_random_tracks();
        test_backpressure();
        test_integral_windup();

        while (pending_drives.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/lfpd_pkg.sv
rtl/lfpd_cfg_regs.sv
rtl/lfpd_pid_path.sv
rtl/lfpd_drive_sched.sv
rtl/line_follow_pd_drive_step_core.sv
verif/tb.sv
